FILE: sv/sspb_pkg.sv
// shared types and constants for the scaled sprite blitter
`timescale 1ns / 1ps

package sspb_pkg;

    localparam int BITS_W  = 16;
    localparam int WIDTH_W = 5;
    localparam int ADDR_W  = 20;
    localparam int COLOR_W = 24;
    localparam int SCALE_W = 2;
    localparam int IDX_W   = 5;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(2);

    typedef struct packed {
        logic [BITS_W-1:0]  row_bits;
        logic [WIDTH_W-1:0] row_width;
        logic               first_row;
        logic [ADDR_W-1:0]  start_address;
        logic [COLOR_W-1:0] draw_color;
    } row_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  write_address;
        logic [COLOR_W-1:0] write_color;
        logic               last_of_row;
    } wr_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    // address steps the shared adder can apply
    typedef enum logic [2:0] {
        DELTA_X,
        DELTA_Y,
        DELTA_PIX,
        DELTA_SKIP,
        DELTA_ROW
    } delta_e;

    typedef enum logic {
        OPA_CUR,
        OPA_BASE
    } opa_e;

    typedef struct packed {
        opa_e   opa;
        delta_e delta;
    } alu_op_t;

endpackage

FILE: sv/sspb_if.sv
// handshake channels for sprite rows, pixel writes and the scale register
`timescale 1ns / 1ps

interface sspb_row_if
    import sspb_pkg::*;
();
    logic valid;
    logic ready;
    row_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sspb_wr_if
    import sspb_pkg::*;
();
    logic valid;
    logic ready;
    wr_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sspb_cfg_if
    import sspb_pkg::*;
();
    logic valid;
    logic ready;
    cfg_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/scaled_sprite_blitter_transparent_core.sv
// top level of the scaled 1bpp sprite blitter with transparency
// a row item is loaded, then each sprite pixel is scanned and each set pixel gives
// scale * scale screen writes, which wait while the sink is not ready
// the first write goes via the load, scan and emit states into the output register
// one write per cycle at most, set by the single shared address adder
// reset: scale register returns to 2, row address to 0, output register empties
`timescale 1ns / 1ps

module scaled_sprite_blitter_transparent_core
    import sspb_pkg::*;
#(
    parameter int MAX_WIDTH       = 16,
    parameter int BYTES_PER_PIXEL = 3,
    parameter int LINE_PIXELS     = 640,
    parameter int MAX_SCALE       = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    sspb_cfg_if.sink   cfg,
    sspb_row_if.sink   row,
    sspb_wr_if.source  wr
);

    logic [SCALE_W-1:0] scale_reg;
    logic               out_valid_reg, out_valid_next;
    wr_t                out_data_reg;

    logic               dbl;
    logic               busy;
    logic               start;
    logic               emit;
    logic               out_free;
    wr_t                seq_wr;
    alu_op_t            alu_op;
    logic [ADDR_W-1:0]  alu_sum;
    logic [ADDR_W-1:0]  cur;
    logic [ADDR_W-1:0]  base;

    // scale of 0 acts as 1, anything above the limit acts as the limit
    assign dbl      = (MAX_SCALE > 1) && scale_reg[1];
    assign start    = row.valid && !busy;
    assign out_free = !out_valid_reg || wr.ready;

    assign cfg.ready = 1'b1;
    assign row.ready = !busy;
    assign wr.valid  = out_valid_reg;
    assign wr.data   = out_data_reg;

    sspb_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (row.data),
        .dbl      (dbl),
        .out_free (out_free),
        .alu_sum  (alu_sum),
        .alu_op   (alu_op),
        .cur      (cur),
        .base     (base),
        .busy     (busy),
        .emit     (emit),
        .wr       (seq_wr)
    );

    sspb_addr_alu #(
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
        .LINE_PIXELS     (LINE_PIXELS)
    ) u_alu (
        .op   (alu_op),
        .dbl  (dbl),
        .cur  (cur),
        .base (base),
        .sum  (alu_sum)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (wr.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                scale_reg <= cfg.data.scale;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= seq_wr;
        end
    end

endmodule

FILE: sv/sspb_addr_alu.sv
// shared address adder with selectable operand and step
`timescale 1ns / 1ps

module sspb_addr_alu
    import sspb_pkg::*;
#(
    parameter int BYTES_PER_PIXEL = 3,
    parameter int LINE_PIXELS     = 640
) (
    input  alu_op_t           op,
    input  logic              dbl,
    input  logic [ADDR_W-1:0] cur,
    input  logic [ADDR_W-1:0] base,
    output logic [ADDR_W-1:0] sum
);

    localparam int LINE_BYTES = BYTES_PER_PIXEL * LINE_PIXELS;

    localparam logic [ADDR_W-1:0] STEP_X     = ADDR_W'(BYTES_PER_PIXEL);
    // from end of first sub-line back to start of the second
    localparam logic [ADDR_W-1:0] STEP_Y     = ADDR_W'(LINE_BYTES - BYTES_PER_PIXEL);
    // from last sub-pixel of a 2x2 block to the next block's top left
    localparam logic [ADDR_W-1:0] STEP_PIX2  = ADDR_W'(BYTES_PER_PIXEL - LINE_BYTES);
    localparam logic [ADDR_W-1:0] STEP_SKIP2 = ADDR_W'(2 * BYTES_PER_PIXEL);
    localparam logic [ADDR_W-1:0] STEP_ROW1  = ADDR_W'(LINE_BYTES);
    localparam logic [ADDR_W-1:0] STEP_ROW2  = ADDR_W'(2 * LINE_BYTES);

    logic [ADDR_W-1:0] opa;
    logic [ADDR_W-1:0] opb;

    always_comb
    begin
        opa = (op.opa == OPA_BASE) ? base : cur;
        unique case (op.delta)
            DELTA_X:    opb = STEP_X;
            DELTA_Y:    opb = STEP_Y;
            DELTA_PIX:  opb = dbl ? STEP_PIX2 : STEP_X;
            DELTA_SKIP: opb = dbl ? STEP_SKIP2 : STEP_X;
            DELTA_ROW:  opb = dbl ? STEP_ROW2 : STEP_ROW1;
            default:    opb = STEP_X;
        endcase
        sum = opa + opb;
    end

endmodule

FILE: sv/sspb_seq.sv
// row sequencer: scans sprite bits and walks sub-pixels through the shared adder
`timescale 1ns / 1ps

module sspb_seq
    import sspb_pkg::*;
#(
    parameter int MAX_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  row_t              item,
    input  logic              dbl,
    input  logic              out_free,
    input  logic [ADDR_W-1:0] alu_sum,
    output alu_op_t           alu_op,
    output logic [ADDR_W-1:0] cur,
    output logic [ADDR_W-1:0] base,
    output logic              busy,
    output logic              emit,
    output wr_t               wr
);

    localparam logic [5:0] WIDTH_CAP = 6'(MAX_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]    cur_reg, cur_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 x_reg, x_next;
    logic                 y_reg, y_next;
    logic [BITS_W-1:0]    bits_reg, bits_next;
    logic [COLOR_W-1:0]   color_reg, color_next;

    logic [5:0]           width_clamp;
    logic                 cur_bit;
    logic [BITS_W-1:0]    below;
    logic                 lower_any;
    logic                 last_sub;

    always_comb
    begin
        width_clamp = ({1'b0, item.row_width} > WIDTH_CAP) ? WIDTH_CAP
                                                           : {1'b0, item.row_width};
        cur_bit = (idx_reg < IDX_W'(BITS_W)) ? bits_reg[idx_reg[3:0]] : 1'b0;
        for (int i = 0; i < BITS_W; i++)
        begin
            below[i] = bits_reg[i] && (IDX_W'(i) < idx_reg);
        end
        lower_any = |below;
        last_sub  = (x_reg == dbl) && (y_reg == dbl);
        base      = item.first_row ? item.start_address : row_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        bits_next  = bits_reg;
        color_next = color_reg;
        alu_op     = '{opa: OPA_CUR, delta: DELTA_X};
        emit       = 1'b0;
        wr.write_address = cur_reg;
        wr.write_color   = color_reg;
        wr.last_of_row   = last_sub && !lower_any;

        unique case (state_reg)
            S_IDLE:
            begin
                alu_op = '{opa: OPA_BASE, delta: DELTA_ROW};
                if (start)
                begin
                    row_next   = alu_sum;
                    cur_next   = base;
                    bits_next  = item.row_bits;
                    color_next = item.draw_color;
                    x_next     = 1'b0;
                    y_next     = 1'b0;
                    idx_next   = IDX_W'(width_clamp - 6'd1);
                    if (width_clamp != 6'd0)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                alu_op = '{opa: OPA_CUR, delta: DELTA_SKIP};
                if (cur_bit)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cur_next = alu_sum;
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                priority if (last_sub)
                begin
                    alu_op = '{opa: OPA_CUR, delta: DELTA_PIX};
                end
                else if (x_reg != dbl)
                begin
                    alu_op = '{opa: OPA_CUR, delta: DELTA_X};
                end
                else
                begin
                    alu_op = '{opa: OPA_CUR, delta: DELTA_Y};
                end
                if (out_free)
                begin
                    emit     = 1'b1;
                    cur_next = alu_sum;
                    priority if (last_sub)
                    begin
                        x_next = 1'b0;
                        y_next = 1'b0;
                        if (idx_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg - 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    else if (x_reg != dbl)
                    begin
                        x_next = 1'b1;
                    end
                    else
                    begin
                        x_next = 1'b0;
                        y_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            idx_reg   <= '0;
            x_reg     <= 1'b0;
            y_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            idx_reg   <= idx_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        bits_reg  <= bits_next;
        color_reg <= color_next;
    end

    assign cur  = cur_reg;
    assign busy = (state_reg != S_IDLE);

endmodule
